// File: src/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

	// channel full scale and hue resolution
	localparam int unsigned CHANNEL_MAX = 255;
	localparam int unsigned HUE_BITS    = 14;

	// fixed field widths of the ports
	localparam int unsigned IN_LVL_W = 8;
	localparam int unsigned OUT_W    = 8;
	localparam int unsigned OUT_MAX  = 255;
	localparam int unsigned NUM_CH   = 3;

	// derived widths
	localparam int unsigned LVL_W      = $clog2(CHANNEL_MAX + 1);
	localparam int unsigned H6_MAX     = 6 * CHANNEL_MAX;
	localparam int unsigned H6_W       = $clog2(H6_MAX + 1);
	localparam int unsigned HUE_PROD_W = HUE_BITS + H6_W;
	localparam int unsigned HUE_HALF   = 1 << (HUE_BITS - 1);
	localparam int unsigned DEN        = CHANNEL_MAX * CHANNEL_MAX;
	localparam int unsigned TERM_W     = $clog2(DEN + 1);

	// rounded product before the divide by full scale squared
	localparam longint unsigned PROD_MAX = longint'(DEN) * CHANNEL_MAX + DEN / 2;
	localparam int unsigned     PROD_W   = $clog2(PROD_MAX + 1);

	// reciprocal of the divisor, estimate is low by at most one
	localparam longint unsigned RECIP   = (64'd1 << PROD_W) / DEN;
	localparam int unsigned     RECIP_W = $clog2(RECIP + 1);

	// sextant boundaries on the scaled hue
	localparam logic [H6_W-1:0] SX1 = H6_W'(CHANNEL_MAX);
	localparam logic [H6_W-1:0] SX2 = H6_W'(2 * CHANNEL_MAX);
	localparam logic [H6_W-1:0] SX3 = H6_W'(3 * CHANNEL_MAX);
	localparam logic [H6_W-1:0] SX4 = H6_W'(4 * CHANNEL_MAX);
	localparam logic [H6_W-1:0] SX5 = H6_W'(5 * CHANNEL_MAX);
	localparam logic [H6_W-1:0] SX6 = H6_W'(6 * CHANNEL_MAX);

	// channel lane order
	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		logic [IN_LVL_W-1:0] saturation;
		logic [IN_LVL_W-1:0] value;
	} hsv_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} rgb_word_t;

	// scaled hue stage
	typedef struct packed {
		logic [H6_W-1:0]  h6;
		logic [LVL_W-1:0] sat;
		logic [LVL_W-1:0] val;
	} hue_stage_t;

	// pure-hue levels stage
	typedef struct packed {
		logic [NUM_CH-1:0][LVL_W-1:0] lvl;
		logic [LVL_W-1:0]             sat;
		logic [LVL_W-1:0]             val;
		logic [TERM_W-1:0]            grey;
	} level_stage_t;

endpackage

`default_nettype wire

// File: src/hsv2rgb_hue.sv
`default_nettype none

module hsv2rgb_hue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   vld,
	input  hsv2rgb_pkg::hsv_word_t      hsv,
	output logic                        vld_s1,
	output hsv2rgb_pkg::hue_stage_t     stg_s1
);
	import hsv2rgb_pkg::*;

	logic [HUE_PROD_W-1:0] prod;
	logic [LVL_W-1:0]      sat_clip;
	logic [LVL_W-1:0]      val_clip;

	// hue scaled to sextant units with rounding
	assign prod = HUE_PROD_W'(hsv.hue) * HUE_PROD_W'(H6_MAX) + HUE_PROD_W'(HUE_HALF);

	// clamp levels to full scale
	always_comb begin
		if (32'(hsv.saturation) > CHANNEL_MAX) begin
			sat_clip = LVL_W'(CHANNEL_MAX);
		end else begin
			sat_clip = LVL_W'(hsv.saturation);
		end
		if (32'(hsv.value) > CHANNEL_MAX) begin
			val_clip = LVL_W'(CHANNEL_MAX);
		end else begin
			val_clip = LVL_W'(hsv.value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		stg_s1.h6  <= prod[HUE_PROD_W-1 -: H6_W];
		stg_s1.sat <= sat_clip;
		stg_s1.val <= val_clip;
	end

endmodule

`default_nettype wire

// File: src/hsv2rgb_sextant.sv
`default_nettype none

module hsv2rgb_sextant (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   vld_s1,
	input  hsv2rgb_pkg::hue_stage_t     stg_s1,
	output logic                        vld_s2,
	output hsv2rgb_pkg::level_stage_t   stg_s2
);
	import hsv2rgb_pkg::*;

	logic [LVL_W-1:0]  lvl_r;
	logic [LVL_W-1:0]  lvl_g;
	logic [LVL_W-1:0]  lvl_b;
	logic [LVL_W-1:0]  full;
	logic [H6_W-1:0]   h6;
	logic [TERM_W-1:0] grey;

	assign full = LVL_W'(CHANNEL_MAX);
	assign h6   = stg_s1.h6;

	// grey part of each channel, (full - sat) * full
	assign grey = TERM_W'(TERM_W'(full - stg_s1.sat) * TERM_W'(CHANNEL_MAX));

	// pure-hue level per channel over the six sextants
	always_comb begin
		lvl_r = '0;
		lvl_g = '0;
		lvl_b = '0;
		if (stg_s1.sat != '0) begin
			if (h6 < SX1) begin
				lvl_r = full;
				lvl_g = LVL_W'(h6);
			end else if (h6 < SX2) begin
				lvl_r = LVL_W'(SX2 - h6);
				lvl_g = full;
			end else if (h6 < SX3) begin
				lvl_g = full;
				lvl_b = LVL_W'(h6 - SX2);
			end else if (h6 < SX4) begin
				lvl_g = LVL_W'(SX4 - h6);
				lvl_b = full;
			end else if (h6 < SX5) begin
				lvl_r = LVL_W'(h6 - SX4);
				lvl_b = full;
			end else if (h6 < SX6) begin
				lvl_r = full;
				lvl_b = LVL_W'(SX6 - h6);
			end else begin
				// top half step wraps to red
				lvl_r = full;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		stg_s2.lvl[CH_RED]   <= lvl_r;
		stg_s2.lvl[CH_GREEN] <= lvl_g;
		stg_s2.lvl[CH_BLUE]  <= lvl_b;
		stg_s2.sat           <= stg_s1.sat;
		stg_s2.val           <= stg_s1.val;
		stg_s2.grey          <= grey;
	end

endmodule

`default_nettype wire

// File: src/hsv2rgb_mix.sv
`default_nettype none

module hsv2rgb_mix (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   vld_s2,
	input  hsv2rgb_pkg::level_stage_t   stg_s2,
	output logic                        vld_s6,
	output hsv2rgb_pkg::rgb_word_t      rgb_s6
);
	import hsv2rgb_pkg::*;

	logic                               vld_s3;
	logic                               vld_s4;
	logic                               vld_s5;
	logic [NUM_CH-1:0][TERM_W-1:0]      term_s3;
	logic [LVL_W-1:0]                   val_s3;
	logic [NUM_CH-1:0][PROD_W-1:0]      prod_s4;
	logic [NUM_CH-1:0][PROD_W-1:0]      prod_s5;
	logic [NUM_CH-1:0][RECIP_W-1:0]     quo_s5;
	logic [NUM_CH-1:0][PROD_W-1:0]      rem;
	logic [NUM_CH-1:0][RECIP_W:0]       quo_fix;
	logic [NUM_CH-1:0][OUT_W-1:0]       chan;

	// valid bits along the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// level times saturation plus grey part
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			term_s3[i] <= TERM_W'(TERM_W'(stg_s2.lvl[i]) * TERM_W'(stg_s2.sat))
				+ stg_s2.grey;
		end
		val_s3 <= stg_s2.val;
	end

	// times value, plus half the divisor for rounding
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			prod_s4[i] <= PROD_W'(PROD_W'(term_s3[i]) * PROD_W'(val_s3))
				+ PROD_W'(DEN / 2);
		end
	end

	// quotient estimate through the reciprocal
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			quo_s5[i]  <= RECIP_W'(((PROD_W + RECIP_W)'(prod_s4[i])
				* (PROD_W + RECIP_W)'(RECIP)) >> PROD_W);
			prod_s5[i] <= prod_s4[i];
		end
	end

	// remainder check fixes an estimate one low, then clip to output range
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			rem[i] = prod_s5[i] - PROD_W'(PROD_W'(quo_s5[i]) * PROD_W'(DEN));
			if (rem[i] >= PROD_W'(DEN)) begin
				quo_fix[i] = (RECIP_W + 1)'(quo_s5[i]) + 1'b1;
			end else begin
				quo_fix[i] = (RECIP_W + 1)'(quo_s5[i]);
			end
			if (32'(quo_fix[i]) > OUT_MAX) begin
				chan[i] = OUT_W'(OUT_MAX);
			end else begin
				chan[i] = OUT_W'(quo_fix[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		rgb_s6.red   <= chan[CH_RED];
		rgb_s6.green <= chan[CH_GREEN];
		rgb_s6.blue  <= chan[CH_BLUE];
	end

endmodule

`default_nettype wire

// File: src/hsv_to_rgb_converter.sv
`default_nettype none

// HSV to RGB color converter, fully pipelined, no internal state.
//
// Input: drive hsv (14-bit hue, 8-bit saturation, 8-bit value) and raise
// start. A word is taken at every rising edge with start high and busy low.
// busy is always low, so a new word may enter on every clock cycle.
//
// Output: each word comes back as red, green and blue on rgb, with done
// high for exactly one cycle. Each word passes the registered stages s1
// to s6 in order, and done and rgb both come from the last of them.
// Words leave in the order they entered, one per cycle at full rate.
//
// Stages: hue scaling multiply, sextant select with grey term, level times
// saturation, times value, reciprocal multiply, remainder correction.
// Each stage holds at most one multiplier per channel.
//
// Reset clears only the valid bits, so no done is raised until new words
// arrive. The receiver cannot stall: done is a strobe and rgb holds valid
// data only in that cycle.

module hsv_to_rgb_converter (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  hsv2rgb_pkg::hsv_word_t      hsv,
	output logic                        done,
	output hsv2rgb_pkg::rgb_word_t      rgb
);
	import hsv2rgb_pkg::*;

	logic         accept;
	logic         vld_s1;
	logic         vld_s2;
	hue_stage_t   stg_s1;
	level_stage_t stg_s2;

	// pipeline never backs up
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	hsv2rgb_hue u_hue (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (accept),
		.hsv    (hsv),
		.vld_s1 (vld_s1),
		.stg_s1 (stg_s1)
	);

	hsv2rgb_sextant u_sextant (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.stg_s1 (stg_s1),
		.vld_s2 (vld_s2),
		.stg_s2 (stg_s2)
	);

	hsv2rgb_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s2 (vld_s2),
		.stg_s2 (stg_s2),
		.vld_s6 (done),
		.rgb_s6 (rgb)
	);

endmodule

`default_nettype wire

// File: tb/rgb_checker.sv
`timescale 1ns / 100ps

module rgb_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             busy,
	input  hsv2rgb_pkg::hsv_word_t hsv,
	input  wire logic             done,
	input  hsv2rgb_pkg::rgb_word_t rgb,
	output int unsigned           fault_count,
	output int unsigned           pending
);

	import hsv2rgb_pkg::*;

	// colors still owed by the block, oldest first
	rgb_word_t rgb_fifo[$];
	int unsigned mismatch_count;

	// blend of pure-hue level toward grey, then scaled by value, rounded
	function automatic logic [OUT_W-1:0] mix_level(longint unsigned lvl,
		longint unsigned sat, longint unsigned val);
		longint unsigned den;
		longint unsigned res;
		den = longint'(CHANNEL_MAX) * CHANNEL_MAX;
		res = ((lvl * sat + (CHANNEL_MAX - sat) * CHANNEL_MAX) * val + den / 2) / den;
		if (res > OUT_MAX)
			res = OUT_MAX;
		return res[OUT_W-1:0];
	endfunction

	// color the block must produce for one hsv word
	function automatic rgb_word_t expected_rgb(hsv_word_t w);
		longint unsigned cm;
		longint unsigned sat;
		longint unsigned val;
		longint unsigned h6;
		longint unsigned r;
		longint unsigned g;
		longint unsigned b;
		rgb_word_t o;
		cm = CHANNEL_MAX;
		sat = (w.saturation > cm) ? cm : w.saturation;
		val = (w.value > cm) ? cm : w.value;
		h6 = (64'(w.hue) * 6 * cm + (64'd1 << (HUE_BITS - 1))) >> HUE_BITS;
		r = 0;
		g = 0;
		b = 0;
		// sextant walk, zero saturation leaves all levels at zero
		if (sat != 0) begin
			if (h6 < cm) begin
				r = cm;
				g = h6;
			end else if (h6 < 2 * cm) begin
				r = 2 * cm - h6;
				g = cm;
			end else if (h6 < 3 * cm) begin
				g = cm;
				b = h6 - 2 * cm;
			end else if (h6 < 4 * cm) begin
				g = 4 * cm - h6;
				b = cm;
			end else if (h6 < 5 * cm) begin
				r = h6 - 4 * cm;
				b = cm;
			end else if (h6 < 6 * cm) begin
				r = cm;
				b = 6 * cm - h6;
			end else begin
				// last half step wraps to red
				r = cm;
			end
		end
		o.red   = mix_level(r, sat, val);
		o.green = mix_level(g, sat, val);
		o.blue  = mix_level(b, sat, val);
		return o;
	endfunction

	initial begin
		fault_count = 0;
		mismatch_count = 0;
		pending = 0;
	end

	// record accepted words, then match each strobed color to the oldest
	always @(posedge clk) begin
		rgb_word_t exp_rgb;
		if (arst_n) begin
			if (start && !busy)
				rgb_fifo.push_back(expected_rgb(hsv));
			if (done) begin
				if (rgb_fifo.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: color word with none pending: r %0d g %0d b %0d",
							$realtime, rgb.red, rgb.green, rgb.blue);
				end else begin
					exp_rgb = rgb_fifo.pop_front();
					if (rgb.red !== exp_rgb.red || rgb.green !== exp_rgb.green ||
						rgb.blue !== exp_rgb.blue) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: color mismatch: exp r %0d g %0d b %0d, got r %0d g %0d b %0d",
								$realtime, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
								rgb.red, rgb.green, rgb.blue);
					end
				end
			end
			fault_count = mismatch_count;
			pending = rgb_fifo.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

	import hsv2rgb_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	hsv_word_t hsv;
	rgb_word_t rgb;
	int unsigned fault_count;
	int unsigned pending;
	int unsigned idle_pct;

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hsv_to_rgb_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.hsv    (hsv),
		.done   (done),
		.rgb    (rgb)
	);

	rgb_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.hsv         (hsv),
		.done        (done),
		.rgb         (rgb),
		.fault_count (fault_count),
		.pending     (pending)
	);

	// offer one word, with random idle cycles ahead of it
	task automatic send_word(input hsv_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			hsv <= hsv_word_t'($bits(hsv_word_t)'($urandom));
			@(negedge clk);
		end
		start <= 1'b1;
		hsv <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop sending until every owed color has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		hsv_word_t w;
		// hues near the sextant edges, and the wrap to red at the top of the circle
		logic [HUE_BITS-1:0] edge_hues [14] = '{14'd0, 14'd2730, 14'd2731, 14'd5461,
			14'd5462, 14'd8191, 14'd8192, 14'd10922, 14'd10923, 14'd13652,
			14'd13653, 14'd16378, 14'd16379, 14'd16383};
		int unsigned phase_pct [3] = '{37, 71, 0};

		arst_n = 1'b0;
		start = 1'b0;
		hsv = '0;
		idle_pct = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: full color around the circle
		foreach (edge_hues[i]) begin
			w.hue = edge_hues[i];
			w.saturation = 8'd255;
			w.value = 8'd255;
			send_word(w);
		end
		// grey, black and near-extreme levels
		w = '{hue: 14'd5000, saturation: 8'd0, value: 8'd200};
		send_word(w);
		w = '{hue: 14'd16383, saturation: 8'd0, value: 8'd0};
		send_word(w);
		w = '{hue: 14'd7000, saturation: 8'd255, value: 8'd0};
		send_word(w);
		w = '{hue: 14'd1000, saturation: 8'd1, value: 8'd255};
		send_word(w);
		w = '{hue: 14'd12000, saturation: 8'd128, value: 8'd1};
		send_word(w);
		w = '{hue: 14'd9000, saturation: 8'd255, value: 8'd128};
		send_word(w);
		drain();

		// random words, light then heavy then no idling on the send side
		for (int p = 0; p < 3; p++) begin
			idle_pct = phase_pct[p];
			repeat (545) begin
				w.hue = HUE_BITS'($urandom);
				if ($urandom_range(15) == 0)
					w.hue = HUE_BITS'($urandom_range(16383, 16370));
				w.saturation = ($urandom_range(7) == 0) ? 8'd0 :
					($urandom_range(7) == 0) ? 8'd255 : 8'($urandom);
				w.value = ($urandom_range(7) == 0) ? 8'd0 :
					($urandom_range(7) == 0) ? 8'd255 : 8'($urandom);
				send_word(w);
			end
			drain();
		end

		repeat (20) @(negedge clk);
		if (fault_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/hsv2rgb_pkg.sv
src/hsv2rgb_hue.sv
src/hsv2rgb_sextant.sv
src/hsv2rgb_mix.sv
src/hsv_to_rgb_converter.sv
tb/rgb_checker.sv
tb/tb.sv
